[src/lzsd_pkg.sv]
// Shared types and constants for the LZSS stream decoder.
// No dependencies; imported by lzsd_hist and lzss_stream_decoder_core.
package lzsd_pkg;

  localparam int RING_SIZE = 4096;
  localparam int RING_AW   = $clog2(RING_SIZE);
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 5;
  localparam int MIN_MATCH = 3;
  localparam int MAX_MATCH = 18;

  typedef logic [RING_AW-1:0] ring_addr_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  // Write pointer position after a stream restart
  localparam ring_addr_t WP_START = ring_addr_t'(RING_SIZE - MAX_MATCH);
  localparam byte_t      FILL_RESET = 8'd32;
  localparam logic [3:0] FLAG_UNITS = 4'd8;

  // Request bundle from the decoder control to the history ring
  typedef struct packed {
    logic       restart;
    byte_t      fill;
    logic       wr_en;
    byte_t      wr_data;
    logic       rd_en;
    ring_addr_t rd_addr;
  } hist_req_t;

endpackage

[src/lzss_stream_decoder_core.sv]
// LZSS stream decoder, 4 KiB history window. A literal is output the cycle
// after its transfer; copy bytes pass the ring's registered read and the output
// register. Flag bytes, pair first bytes, literals and copy bytes move one per
// cycle while the output is free; a pair second byte starts an n-byte copy
// (n = 3..18) via the ring's single read port, and input waits until it ends.
// Reset (rst_n, synchronous, active low) clears control only; the ring is not
// swept: a fill count makes unwritten entries read as the fill byte.
module lzss_stream_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tuser,   // [0] start_of_stream
  // output stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // last_of_run
  // configuration
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data // fill_value
);
  import lzsd_pkg::*;

  // Kind of an accepted compressed byte
  localparam logic [1:0] KIND_FLAG = 2'd0;
  localparam logic [1:0] KIND_POS  = 2'd1;
  localparam logic [1:0] KIND_PAIR = 2'd2;
  localparam logic [1:0] KIND_LIT  = 2'd3;

  byte_t            fill_value_r;
  byte_t            flags_r, flags_nxt;
  logic [3:0]       units_r, units_nxt;
  logic             await_r, await_nxt;
  byte_t            pos_lo_r, pos_lo_nxt;
  logic [LEN_W-1:0] cnt_r, cnt_nxt;
  ring_addr_t       rd_ptr_r, rd_ptr_nxt;
  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_last_r, s1_last_nxt;
  logic             out_valid_r, out_valid_nxt;
  byte_t            out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic       out_free;
  logic       s1_adv;
  logic       issue;
  logic       accept;
  logic       lit;
  logic [1:0] kind;
  hist_req_t  hreq;
  byte_t      hist_data;

  // Handshake
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign issue     = (cnt_r != '0) && (!s1_valid_r || s1_adv);
  assign in_tready = (cnt_r == '0) && !s1_valid_r && out_free;
  assign accept    = in_tvalid && in_tready;

  // Classify the incoming byte
  always_comb begin
    if (in_tuser || units_r == '0) begin
      kind = KIND_FLAG;
    end else if (await_r) begin
      kind = KIND_PAIR;
    end else if (flags_r[0]) begin
      kind = KIND_LIT;
    end else begin
      kind = KIND_POS;
    end
  end

  assign lit = accept && (kind == KIND_LIT);

  // Ring requests: writes go at the ring's own pointer
  always_comb begin
    hreq.restart = accept && in_tuser;
    hreq.fill    = fill_value_r;
    hreq.wr_en   = s1_adv || lit;
    hreq.wr_data = s1_adv ? hist_data : in_tdata;
    hreq.rd_en   = issue;
    hreq.rd_addr = rd_ptr_r;
  end

  lzsd_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (hreq),
    .rd_data (hist_data)
  );

  // Decode state and copy sequencer
  always_comb begin
    flags_nxt  = flags_r;
    units_nxt  = units_r;
    await_nxt  = await_r;
    pos_lo_nxt = pos_lo_r;
    cnt_nxt    = cnt_r;
    rd_ptr_nxt = rd_ptr_r;
    if (issue) begin
      cnt_nxt    = cnt_r - LEN_W'(1);
      rd_ptr_nxt = rd_ptr_r + ring_addr_t'(1);
    end
    if (accept) begin
      unique case (kind)
        KIND_FLAG: begin
          flags_nxt = in_tdata;
          units_nxt = FLAG_UNITS;
          await_nxt = 1'b0;
        end
        KIND_POS: begin
          pos_lo_nxt = in_tdata;
          await_nxt  = 1'b1;
        end
        KIND_PAIR: begin
          rd_ptr_nxt = {in_tdata[7:4], pos_lo_r};
          cnt_nxt    = {1'b0, in_tdata[3:0]} + LEN_W'(MIN_MATCH);
          await_nxt  = 1'b0;
          flags_nxt  = flags_r >> 1;
          units_nxt  = units_r - 4'd1;
        end
        KIND_LIT: begin
          flags_nxt = flags_r >> 1;
          units_nxt = units_r - 4'd1;
        end
        default: begin
          await_nxt = await_r;
        end
      endcase
    end
  end

  // Read-data stage and output register
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_last_nxt   = s1_last_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (issue) begin
      s1_valid_nxt = 1'b1;
      s1_last_nxt  = (cnt_r == LEN_W'(1));
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_adv || lit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = hreq.wr_data;
      out_last_nxt  = s1_adv ? s1_last_r : 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_value_r <= FILL_RESET;
      flags_r      <= '0;
      units_r      <= '0;
      await_r      <= 1'b0;
      cnt_r        <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fill_value_r <= cfg_wr_data;
      end
      flags_r     <= flags_nxt;
      units_r     <= units_nxt;
      await_r     <= await_nxt;
      cnt_r       <= cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_lo_r   <= pos_lo_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    s1_last_r  <= s1_last_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LEN_W'(MAX_MATCH))
    else $error("copy count above maximum match length");

  a_pair_len: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && kind == KIND_PAIR) |=> (cnt_r >= LEN_W'(MIN_MATCH)))
    else $error("pair transfer did not start a copy of at least three bytes");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |=> (s1_valid_r && $stable(s1_last_r)))
    else $error("read stage dropped a byte under output stall");

  a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> (s1_valid_r || cnt_r != '0))
    else $error("copy run ended without a last byte");
`endif

endmodule

[src/lzsd_hist.sv]
// History ring of the LZSS decoder: 4096 x 8 synchronous RAM, write pointer,
// fill tracking and same-cycle write forwarding. Depends on lzsd_pkg.
module lzsd_hist (
  input  logic              clk,
  input  logic              rst_n,
  input  lzsd_pkg::hist_req_t req,
  output lzsd_pkg::byte_t   rd_data
);
  import lzsd_pkg::*;

  byte_t            mem [RING_SIZE];
  byte_t            mem_q_r;
  byte_t            fwd_byte_r;
  logic             sel_fwd_r;
  logic             sel_fill_r;
  byte_t            fill_byte_r, fill_byte_nxt;
  ring_addr_t       wp_r, wp_nxt;
  logic [RING_AW:0] fill_cnt_r, fill_cnt_nxt;
  ring_addr_t       rd_ofs;
  logic             rd_written;
  logic             rd_hit;

  // Entries written since restart form a run starting at WP_START
  assign rd_ofs     = req.rd_addr - WP_START;
  assign rd_written = {1'b0, rd_ofs} < fill_cnt_r;
  // Read of the entry being written at this same edge
  assign rd_hit     = req.wr_en && (req.rd_addr == wp_r);

  // RAM: one write port at the write pointer, one registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wp_r] <= req.wr_data;
    end
    if (req.rd_en) begin
      mem_q_r <= mem[req.rd_addr];
    end
  end

  // Read source select, registered alongside the RAM data
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      sel_fwd_r  <= rd_hit;
      sel_fill_r <= !rd_written;
      fwd_byte_r <= req.wr_data;
    end
  end

  assign rd_data = sel_fwd_r ? fwd_byte_r : (sel_fill_r ? fill_byte_r : mem_q_r);

  // Pointer and fill count
  always_comb begin
    wp_nxt        = wp_r;
    fill_cnt_nxt  = fill_cnt_r;
    fill_byte_nxt = fill_byte_r;
    if (req.restart) begin
      wp_nxt        = WP_START;
      fill_cnt_nxt  = '0;
      fill_byte_nxt = req.fill;
    end else if (req.wr_en) begin
      wp_nxt = wp_r + ring_addr_t'(1);
      if (fill_cnt_r != (RING_AW+1)'(RING_SIZE)) begin
        fill_cnt_nxt = fill_cnt_r + (RING_AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= WP_START;
      fill_cnt_r  <= '0;
      fill_byte_r <= FILL_RESET;
    end else begin
      wp_r        <= wp_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      fill_byte_r <= fill_byte_nxt;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= (RING_AW+1)'(RING_SIZE))
    else $error("history fill count exceeds ring size");

  a_restart_clear: assert property (@(posedge clk) disable iff (!rst_n)
    req.restart |=> (fill_cnt_r == '0 && wp_r == WP_START))
    else $error("restart did not rewind the history ring");

  a_wp_follows_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (req.wr_en && !req.restart && fill_cnt_r != (RING_AW+1)'(RING_SIZE))
      |=> (fill_cnt_r == $past(fill_cnt_r) + (RING_AW+1)'(1)))
    else $error("fill count missed a ring write");
`endif

endmodule
